// File: hw/rtl/prl_pkg.sv
// Shared types and constants for the page range list parser.
package prl_pkg;

    // Default width of a page number inside the parser.
    localparam int PAGE_BITS_DEF = 16;

    // Width of page fields on the ports.
    localparam int PORT_PAGE_W = 16;

    // Depth of the result queue; a power of two, at least two.
    localparam int RES_DEPTH = 4;

    // Characters with a meaning in the list.
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Parsing phase within one token.
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_SWALLOW
    } t_phase;

    // Kind of a result.
    typedef enum logic [1:0] {
        KIND_RANGE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // Error codes.
    typedef enum logic [2:0] {
        ERR_EMPTY    = 3'd0,
        ERR_NONDIGIT = 3'd1,
        ERR_NOTPOS   = 3'd2,
        ERR_ABOVE    = 3'd3,
        ERR_DESC     = 3'd4
    } t_err;

    // Outcome of checking a number that closes.
    typedef struct packed {
        logic ok;
        logic err;
        t_err code;
    } t_close;

    // One entry of the result queue.
    typedef struct packed {
        logic [PORT_PAGE_W-1:0] first_page;
        logic [PORT_PAGE_W-1:0] last_page;
        t_kind                  kind;
        t_err                   code;
        logic                   last_of_run;
    } t_result;

endpackage

// File: hw/rtl/page_range_list_parser.sv
// Page range list parser: checks a character stream of page ranges against a page count.
// A character is taken into an input register and processed from there; its results are
// written into a four-entry result queue, whose head drives the output.
// Throughput: one character per cycle while the queue holds at most two entries, else the input
// stalls; a character that yields two results needs two output transfers.
// Reset (synchronous, active low) clears the page count, the parse state and the queue.
module page_range_list_parser #(
    parameter int PAGE_BITS = prl_pkg::PAGE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration
    input  logic        i_page_count_we,
    input  logic [15:0] i_page_count,
    // Character input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_string,
    // Result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_first_page,
    output logic [15:0] o_last_page,
    output logic [1:0]  o_item_kind,
    output logic [2:0]  o_error_code,
    output logic        o_last_of_run
);
    import prl_pkg::*;

    localparam int ACC_W = PAGE_BITS + 1;
    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    // Registered configuration.
    logic [PAGE_BITS-1:0] r_page_count;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eos;

    // Parse state and its next value.
    t_phase               r_phase, n_phase;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic                 r_seen, n_seen;
    logic [PAGE_BITS-1:0] r_first, n_first;
    logic                 r_eflag, n_eflag;
    t_err                 r_ekind, n_ekind;

    // Results of the current character.
    logic                 rng_valid;
    logic [PAGE_BITS-1:0] rng_first;
    logic [PAGE_BITS-1:0] rng_last;
    logic                 stat_valid;
    t_kind                stat_kind;
    t_err                 stat_code;
    t_close               tok_cl;
    t_close               end_cl;
    t_result              rng_res;
    t_result              stat_res;

    // Digit handling.
    logic                 is_digit;
    logic [ACC_W+3:0]     acc_prod;
    logic [ACC_W-1:0]     acc_sat;
    logic                 ends;

    // Result queue.
    t_result              r_fifo [RES_DEPTH];
    logic [PTR_W-1:0]     r_rd;
    logic [PTR_W-1:0]     r_wr;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic                 go;
    logic                 pop;
    logic [1:0]           push_n;

    // Checks of a number at a comma, a hyphen or the end of the list.
    function automatic t_close close_tok(t_phase ph, logic [ACC_W-1:0] v, logic seen,
                                         logic [PAGE_BITS-1:0] first,
                                         logic [PAGE_BITS-1:0] pc);
        t_close r;
        r = '{ok: 1'b0, err: 1'b0, code: ERR_EMPTY};
        unique case (ph)
            PH_FIRST: begin
                if (!seen) begin
                    r.err = 1'b1; r.code = ERR_EMPTY;
                end else if (v == '0) begin
                    r.err = 1'b1; r.code = ERR_NOTPOS;
                end else if (v > ACC_W'(pc)) begin
                    r.err = 1'b1; r.code = ERR_ABOVE;
                end else begin
                    r.ok = 1'b1;
                end
            end
            PH_SECOND: begin
                if (v == '0) begin
                    r.err = 1'b1; r.code = ERR_NOTPOS;
                end else if (v > ACC_W'(pc)) begin
                    r.err = 1'b1; r.code = ERR_ABOVE;
                end else if (v < ACC_W'(first)) begin
                    r.err = 1'b1; r.code = ERR_DESC;
                end else begin
                    r.ok = 1'b1;
                end
            end
            default: begin
                r.ok = 1'b0;
            end
        endcase
        return r;
    endfunction

    // A character is processed when the queue has room for two results.
    assign go         = r_in_valid && (r_cnt <= CNT_W'(RES_DEPTH - 2));
    assign o_in_stall = r_in_valid && !go;

    // Input register: loads on every transfer, empties when processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
        if (i_in_valid && !o_in_stall) begin
            r_char <= i_char_code;
            r_eos  <= i_end_of_string;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= '0;
        end else if (i_page_count_we) begin
            r_page_count <= PAGE_BITS'(i_page_count);
        end
    end

    // Decimal accumulation by ten with saturation.
    assign is_digit = (r_char >= CHAR_ZERO) && (r_char <= CHAR_NINE);
    assign acc_prod = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                    + (ACC_W + 4)'(r_char[3:0]);
    assign acc_sat  = (acc_prod[ACC_W+3:ACC_W] != 4'b0) ? '1 : acc_prod[ACC_W-1:0];
    assign ends     = r_eos || (r_char == CHAR_NUL);

    // The check of the open token uses the registered state.
    assign tok_cl = close_tok(r_phase, r_acc, r_seen, r_first, r_page_count);

    // Next parse state and results for the character in the input register.
    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_seen     = r_seen;
        n_first    = r_first;
        n_eflag    = r_eflag;
        n_ekind    = r_ekind;
        rng_valid  = 1'b0;
        rng_first  = '0;
        rng_last   = '0;
        stat_valid = 1'b0;
        stat_kind  = KIND_DONE;
        stat_code  = ERR_EMPTY;
        end_cl     = '{ok: 1'b0, err: 1'b0, code: ERR_EMPTY};

        // Ordinary handling of the character.
        if (r_char != CHAR_NUL && r_phase != PH_SWALLOW) begin
            if (is_digit) begin
                n_acc  = acc_sat;
                n_seen = 1'b1;
            end else if (r_char == CHAR_COMMA || (r_char == CHAR_HYPHEN && r_phase == PH_FIRST)) begin
                if (tok_cl.err) begin
                    if (!n_eflag) begin
                        n_eflag = 1'b1;
                        n_ekind = tok_cl.code;
                    end
                    n_phase = PH_SWALLOW;
                end else if (r_char == CHAR_COMMA) begin
                    rng_valid = 1'b1;
                    rng_first = (r_phase == PH_SECOND) ? r_first : PAGE_BITS'(r_acc);
                    rng_last  = PAGE_BITS'(r_acc);
                    n_phase   = PH_FIRST;
                    n_acc     = '0;
                    n_seen    = 1'b0;
                end else begin
                    n_first = PAGE_BITS'(r_acc);
                    n_phase = PH_SECOND;
                    n_acc   = '0;
                    n_seen  = 1'b0;
                end
            end else begin
                if (!n_eflag) begin
                    n_eflag = 1'b1;
                    n_ekind = ERR_NONDIGIT;
                end
                n_phase = PH_SWALLOW;
            end
        end

        // End of the list: close the last token, report status, start afresh.
        if (ends) begin
            end_cl = close_tok(n_phase, n_acc, n_seen, n_first, r_page_count);
            if (end_cl.err) begin
                if (!n_eflag) begin
                    n_eflag = 1'b1;
                    n_ekind = end_cl.code;
                end
            end else if (end_cl.ok) begin
                rng_valid = 1'b1;
                rng_first = (n_phase == PH_SECOND) ? n_first : PAGE_BITS'(n_acc);
                rng_last  = PAGE_BITS'(n_acc);
            end
            stat_valid = 1'b1;
            stat_kind  = n_eflag ? KIND_ERROR : KIND_DONE;
            stat_code  = n_eflag ? n_ekind : ERR_EMPTY;
            n_phase    = PH_FIRST;
            n_acc      = '0;
            n_seen     = 1'b0;
            n_first    = '0;
            n_eflag    = 1'b0;
            n_ekind    = ERR_EMPTY;
        end
    end

    // Parse state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_acc   <= '0;
            r_seen  <= 1'b0;
            r_first <= '0;
            r_eflag <= 1'b0;
            r_ekind <= ERR_EMPTY;
        end else if (go) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_seen  <= n_seen;
            r_first <= n_first;
            r_eflag <= n_eflag;
            r_ekind <= n_ekind;
        end
    end

    // Result entries; the range is the last of its run only without a status.
    assign rng_res = '{first_page: PORT_PAGE_W'(rng_first), last_page: PORT_PAGE_W'(rng_last),
                       kind: KIND_RANGE, code: ERR_EMPTY, last_of_run: !stat_valid};
    assign stat_res = '{first_page: '0, last_page: '0, kind: stat_kind, code: stat_code,
                        last_of_run: 1'b1};

    // Queue bookkeeping.
    assign pop    = o_out_valid && !i_out_stall;
    assign push_n = go ? ({1'b0, rng_valid} + {1'b0, stat_valid}) : 2'd0;
    assign n_cnt  = r_cnt + CNT_W'(push_n) - CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_rd  <= r_rd + PTR_W'(pop);
            r_wr  <= r_wr + PTR_W'(push_n);
            r_cnt <= n_cnt;
        end
    end

    // Queue storage: a range goes before the status of the same character.
    always_ff @(posedge i_clk) begin
        if (go) begin
            if (rng_valid && stat_valid) begin
                r_fifo[r_wr]              <= rng_res;
                r_fifo[r_wr + PTR_W'(1)]  <= stat_res;
            end else if (rng_valid) begin
                r_fifo[r_wr] <= rng_res;
            end else if (stat_valid) begin
                r_fifo[r_wr] <= stat_res;
            end
        end
    end

    // Output side reads the head of the queue.
    assign o_out_valid   = (r_cnt != '0);
    assign o_first_page  = r_fifo[r_rd].first_page;
    assign o_last_page   = r_fifo[r_rd].last_page;
    assign o_item_kind   = r_fifo[r_rd].kind;
    assign o_error_code  = r_fifo[r_rd].code;
    assign o_last_of_run = r_fifo[r_rd].last_of_run;

    // The queue never holds more than its depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    // Swallowing only follows a recorded error.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SWALLOW) |-> r_eflag)
        else $error("swallowing without an error");

    // The accumulator holds nothing until a digit arrives.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> (r_acc == '0))
        else $error("accumulator set without a digit");

    // The end of a list returns the parser to a clean first number.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && ends) |=> (r_phase == PH_FIRST && !r_eflag && !r_seen))
        else $error("list end did not restart parsing");

    // A pair in progress always has a positive first page.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SECOND) |-> (r_first != '0))
        else $error("second number without a first page");

endmodule

// File: dv/tb_page_range_list_parser.sv
// Self-checking testbench for the page range list parser, with a built-in predictor.
`timescale 1ns / 1ps

module tb_page_range_list_parser;
    import prl_pkg::*;

    // A run with no transfer for this many cycles is taken as hung; this is far above any
    // stall burst or idle pause.
    localparam int unsigned HANG_LIMIT = 500;
    // Cycles to let the pipeline settle: input register, processing and output stage.
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam logic [16:0] ACC_SATURATED = '1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_page_count_we = 1'b0;
    logic [15:0] i_page_count = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_char_code = '0;
    logic        i_end_of_string = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_first_page;
    logic [15:0] o_last_page;
    logic [1:0]  o_item_kind;
    logic [2:0]  o_error_code;
    logic        o_last_of_run;

    // Predictor state: a copy of the parser's registers and of the page count.
    logic [15:0] page_limit;
    t_phase      list_phase;
    logic [16:0] number_value;
    logic        number_has_digit;
    logic [15:0] pair_first;
    logic        list_failed;
    t_err        list_fault;

    t_result step_results[$];
    t_result expected_results[$];
    logic [7:0] list_chars[$];

    // Run control and tallies.
    bit          idle_on = 1'b1;
    bit          quiet_list = 1'b0;
    int unsigned out_stall_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned fail_count = 0;
    int unsigned chars_sent = 0;
    int unsigned lists_sent = 0;
    int unsigned ranges_seen = 0;
    int unsigned status_seen = 0;
    int unsigned count_writes = 0;

    page_range_list_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_page_count_we (i_page_count_we),
        .i_page_count    (i_page_count),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_code     (i_char_code),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_first_page    (o_first_page),
        .o_last_page     (o_last_page),
        .o_item_kind     (o_item_kind),
        .o_error_code    (o_error_code),
        .o_last_of_run   (o_last_of_run)
    );

    // Clock with a 2 ns period.
    always #1 i_clk = ~i_clk;

    // Clear the parse state so that the next character opens a fresh list.
    function automatic void open_new_list();
        list_phase       = PH_FIRST;
        number_value     = '0;
        number_has_digit = 1'b0;
        pair_first       = '0;
        list_failed      = 1'b0;
        list_fault       = ERR_EMPTY;
    endfunction

    // Only the first error of a list is kept; the rest of the list is swallowed.
    function automatic void flag_error(input t_err code);
        if (!list_failed) begin
            list_failed = 1'b1;
            list_fault  = code;
        end
        list_phase = PH_SWALLOW;
    endfunction

    function automatic void add_result(input logic [15:0] first, input logic [15:0] last,
                                       input t_kind kind, input t_err code);
        t_result res;
        res.first_page  = first;
        res.last_page   = last;
        res.kind        = kind;
        res.code        = code;
        res.last_of_run = 1'b0;
        step_results.push_back(res);
    endfunction

    // A comma or the end of the list closes the token and checks its numbers.
    function automatic void close_token();
        if (list_phase == PH_FIRST) begin
            if (!number_has_digit) begin
                flag_error(ERR_EMPTY);
            end else if (number_value == 0) begin
                flag_error(ERR_NOTPOS);
            end else if (number_value > page_limit) begin
                flag_error(ERR_ABOVE);
            end else begin
                add_result(number_value[15:0], number_value[15:0], KIND_RANGE, ERR_EMPTY);
                number_value     = '0;
                number_has_digit = 1'b0;
            end
        end else if (list_phase == PH_SECOND) begin
            if (number_value == 0) begin
                flag_error(ERR_NOTPOS);
            end else if (number_value > page_limit) begin
                flag_error(ERR_ABOVE);
            end else if (number_value < pair_first) begin
                flag_error(ERR_DESC);
            end else begin
                add_result(pair_first, number_value[15:0], KIND_RANGE, ERR_EMPTY);
                list_phase       = PH_FIRST;
                number_value     = '0;
                number_has_digit = 1'b0;
            end
        end
    endfunction

    // Work out the results of one accepted character and queue them in order.
    function automatic void predict_results(input logic [7:0] code, input logic eos);
        t_result     res;
        int unsigned grown;
        logic        ends;
        step_results.delete();
        ends = eos || (code == CHAR_NUL);
        if (code != CHAR_NUL && list_phase != PH_SWALLOW) begin
            if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
                grown = 32'(number_value) * 10 + 32'(code - CHAR_ZERO);
                number_value     = (grown > 32'(ACC_SATURATED)) ? ACC_SATURATED : grown[16:0];
                number_has_digit = 1'b1;
            end else if (code == CHAR_COMMA) begin
                close_token();
            end else if (code == CHAR_HYPHEN && list_phase == PH_FIRST) begin
                if (!number_has_digit) begin
                    flag_error(ERR_EMPTY);
                end else if (number_value == 0) begin
                    flag_error(ERR_NOTPOS);
                end else if (number_value > page_limit) begin
                    flag_error(ERR_ABOVE);
                end else begin
                    pair_first       = number_value[15:0];
                    list_phase       = PH_SECOND;
                    number_value     = '0;
                    number_has_digit = 1'b0;
                end
            end else begin
                flag_error(ERR_NONDIGIT);
            end
        end
        if (ends) begin
            if (list_phase != PH_SWALLOW) begin
                close_token();
            end
            if (list_failed) begin
                add_result('0, '0, KIND_ERROR, list_fault);
            end else begin
                add_result('0, '0, KIND_DONE, ERR_EMPTY);
            end
            open_new_list();
        end
        foreach (step_results[i]) begin
            res = step_results[i];
            res.last_of_run = (i == step_results.size() - 1);
            expected_results.push_back(res);
        end
    endfunction

    // Random stall bursts on the result side, off in the last part of the run.
    always @(posedge i_clk) begin
        if (out_stall_left > 0) begin
            i_out_stall    <= 1'b1;
            out_stall_left <= out_stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            i_out_stall    <= 1'b1;
            out_stall_left <= $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: first_page %0d last_page %0d item_kind %0d",
                       o_first_page, o_last_page, o_item_kind);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_first_page !== want.first_page) begin
                    $error("first_page: expected %0d, actual %0d", want.first_page, o_first_page);
                    fail_count++;
                end
                if (o_last_page !== want.last_page) begin
                    $error("last_page: expected %0d, actual %0d", want.last_page, o_last_page);
                    fail_count++;
                end
                if (o_item_kind !== want.kind) begin
                    $error("item_kind: expected %0d, actual %0d", want.kind, o_item_kind);
                    fail_count++;
                end
                if (o_error_code !== want.code) begin
                    $error("error_code: expected %0d, actual %0d", want.code, o_error_code);
                    fail_count++;
                end
                if (o_last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, actual %0d",
                           want.last_of_run, o_last_of_run);
                    fail_count++;
                end
                if (want.kind == KIND_RANGE) begin
                    ranges_seen++;
                end else begin
                    status_seen++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one character, with an optional gap before it, and wait for its transfer.
    task automatic send_char(input logic [7:0] code, input logic eos);
        int unsigned gap;
        if (idle_on && !quiet_list && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_char_code     <= code;
        i_end_of_string <= eos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_results(code, eos);
        chars_sent++;
    endtask

    // Send the collected list; it ends either on its last character or on a NUL.
    task automatic send_list(input bit nul_end, input bit nul_eos);
        foreach (list_chars[i]) begin
            send_char(list_chars[i], !nul_end && (i == list_chars.size() - 1));
        end
        if (nul_end) begin
            send_char(CHAR_NUL, nul_eos);
        end
        list_chars.delete();
        lists_sent++;
    endtask

    function automatic void add_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            list_chars.push_back(text[i]);
        end
    endfunction

    function automatic void add_number(input int unsigned value);
        if ($urandom_range(0, 15) == 0) begin
            list_chars.push_back(CHAR_ZERO);
        end
        add_text($sformatf("%0d", value));
    endfunction

    // A page inside the document, with the edges picked more often; pages 1 to 3 when the count is zero.
    function automatic int unsigned pick_page();
        if (page_limit == 0) begin
            return $urandom_range(1, 3);
        end
        case ($urandom_range(0, 7))
            0: return 1;
            1: return 32'(page_limit);
            default: return $urandom_range(1, page_limit);
        endcase
    endfunction

    // Wait until every expected result has arrived and the pipeline has drained.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_page_count(input logic [15:0] value);
        wait_idle();
        i_page_count_we <= 1'b1;
        i_page_count    <= value;
        @(posedge i_clk);
        i_page_count_we <= 1'b0;
        page_limit = value;
        count_writes++;
    endtask

    // Hand-picked lists: each error, the ending rules and two results from one character.
    task automatic test_directed_lists();
        write_page_count(16'd0);
        add_text("1");
        send_list(1'b0, 1'b0);
        write_page_count(16'd20);
        // A comma on the ending character leaves an empty number behind it.
        add_text("1,");
        send_list(1'b0, 1'b0);
        // An empty second number counts as zero.
        add_text("3-");
        send_list(1'b0, 1'b0);
        add_text("5-3");
        send_list(1'b0, 1'b0);
        // A second hyphen in one token is not a digit.
        add_text("1-2-");
        send_list(1'b0, 1'b0);
        add_text("0");
        send_list(1'b0, 1'b0);
        add_text("21");
        send_list(1'b0, 1'b0);
        add_text("7-9,4");
        send_list(1'b0, 1'b0);
        // A lone NUL is an empty list; a NUL ends a list even without the end mark.
        send_list(1'b1, 1'b1);
        add_text("2");
        send_list(1'b1, 1'b0);
        list_chars.push_back(8'hFF);
        send_list(1'b0, 1'b0);
    endtask

    // The largest page count, saturation of long numbers and the smallest non-zero count.
    task automatic test_count_extremes();
        write_page_count(16'hFFFF);
        add_text("65535,1-65535");
        send_list(1'b0, 1'b0);
        add_text("65536");
        send_list(1'b0, 1'b0);
        add_text("99999999999");
        send_list(1'b0, 1'b0);
        write_page_count(16'd1);
        add_text("001,2");
        send_list(1'b0, 1'b0);
    endtask

    // One random list: mostly well-formed tokens, some broken ones, some pure noise.
    task automatic random_list();
        int unsigned tokens;
        int unsigned first;
        int unsigned last;
        int unsigned swap;
        bit          nul_end;
        quiet_list = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) list_chars.push_back(8'($urandom_range(1, 255)));
        end else begin
            tokens = $urandom_range(1, 4);
            for (int t = 0; t < tokens; t++) begin
                if (t > 0) begin
                    list_chars.push_back(CHAR_COMMA);
                end
                first = pick_page();
                last  = pick_page();
                if (first > last) begin
                    swap  = first;
                    first = last;
                    last  = swap;
                end
                if ($urandom_range(0, 99) < 45) begin
                    add_number(first);
                end else if ($urandom_range(0, 99) < 75) begin
                    add_number(first);
                    list_chars.push_back(CHAR_HYPHEN);
                    add_number(last);
                end else begin
                    case ($urandom_range(0, 6))
                        0: ;
                        1: add_number(0);
                        2: add_number(32'(page_limit) + $urandom_range(1, 99));
                        3: begin
                            repeat ($urandom_range(6, 12)) begin
                                list_chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                            end
                        end
                        4: begin
                            add_number(last);
                            list_chars.push_back(CHAR_HYPHEN);
                            add_number(first);
                        end
                        5: begin
                            add_number(first);
                            list_chars.push_back(CHAR_HYPHEN);
                            if ($urandom_range(0, 1) == 1) begin
                                add_number(last);
                                list_chars.push_back(CHAR_HYPHEN);
                                add_number(last);
                            end
                        end
                        default: begin
                            add_number(first);
                            list_chars.push_back(8'($urandom_range(1, 255)));
                            add_number(last);
                        end
                    endcase
                end
            end
        end
        nul_end = (list_chars.size() == 0) || ($urandom_range(0, 7) == 0);
        send_list(nul_end, 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_lists(input logic [15:0] count, input int unsigned chars);
        int unsigned target;
        write_page_count(count);
        target = chars_sent + chars;
        while (chars_sent < target) random_list();
    endtask

    // Test sequence.
    initial begin
        page_limit = '0;
        open_new_list();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_lists();
        test_count_extremes();
        test_random_lists(16'hFFFF, 250);
        test_random_lists(16'd0, 150);
        test_random_lists(16'd1, 150);
        test_random_lists(16'($urandom_range(2, 65534)), 300);
        test_random_lists(16'd300, 300);
        idle_on    = 1'b0;
        quiet_list = 1'b0;
        test_random_lists(16'($urandom_range(1, 1000)), 300);
        wait_idle();

        $display("Sent %0d characters in %0d lists under %0d page count settings.",
                 chars_sent, lists_sent, count_writes);
        $display("Checked %0d ranges and %0d end-of-list status results.",
                 ranges_seen, status_seen);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
